// ===== src/brfifo_pkg.sv =====
// Shared types, codes and the control store for the byte ring FIFO.
// No dependencies; imported by brfifo_seq and byte_ring_fifo_with_line_read.
package brfifo_pkg;

  localparam logic [7:0] NEWLINE   = 8'h0A;
  localparam int         MIN_CAP   = 3;
  localparam logic [5:0] CAP_RESET = 6'd63;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_LINE  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_NOLINE = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_RD,
    S_LN,
    S_POP
  } step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_RD_START,
    OP_LN_START,
    OP_POP
  } op_t;

  // One control word: take a request, wait for the output slot, datapath op,
  // and the two branch targets (op finished / more to do).
  typedef struct packed {
    logic  take_in;
    logic  need_out;
    op_t   op;
    step_t tgt_done;
    step_t tgt_more;
  } ucode_t;

  // Condition flags returned from the datapath to the sequencer.
  typedef struct packed {
    logic       fire;
    logic [1:0] cmd;
    logic       go;
    logic       done;
  } seq_cond_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t uc;
    unique case (s)
      S_IDLE: uc = '{take_in: 1'b1, need_out: 1'b0, op: OP_NONE,
                     tgt_done: S_IDLE, tgt_more: S_IDLE};
      S_WR:   uc = '{take_in: 1'b0, need_out: 1'b1, op: OP_WRITE,
                     tgt_done: S_IDLE, tgt_more: S_IDLE};
      S_RD:   uc = '{take_in: 1'b0, need_out: 1'b1, op: OP_RD_START,
                     tgt_done: S_IDLE, tgt_more: S_POP};
      S_LN:   uc = '{take_in: 1'b0, need_out: 1'b1, op: OP_LN_START,
                     tgt_done: S_IDLE, tgt_more: S_POP};
      S_POP:  uc = '{take_in: 1'b0, need_out: 1'b1, op: OP_POP,
                     tgt_done: S_IDLE, tgt_more: S_POP};
      default: uc = '{take_in: 1'b0, need_out: 1'b0, op: OP_NONE,
                      tgt_done: S_IDLE, tgt_more: S_IDLE};
    endcase
    return uc;
  endfunction

endpackage

// ===== src/brfifo_seq.sv =====
// Step counter and control store sequencer for the byte ring FIFO.
// Depends on brfifo_pkg (step codes, control word, condition struct).
module brfifo_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  brfifo_pkg::seq_cond_t cond,
  output brfifo_pkg::ucode_t    uc
);
  import brfifo_pkg::*;

  step_t step_r, step_nxt;

  assign uc = ucode_rom(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (uc.take_in) begin
      if (cond.fire) begin
        // dispatch on the command; the unused code falls back to idle
        unique case (cond.cmd)
          CMD_WRITE: step_nxt = S_WR;
          CMD_READ:  step_nxt = S_RD;
          CMD_LINE:  step_nxt = S_LN;
          default:   step_nxt = S_IDLE;
        endcase
      end
    end else if (cond.go) begin
      step_nxt = cond.done ? uc.tgt_done : uc.tgt_more;
    end
  end

endmodule

// ===== src/byte_ring_fifo_with_line_read.sv =====
// Byte ring FIFO with counted read and line read, top level.
// Depends on brfifo_pkg and brfifo_seq.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   cfg     | in        | cfg_wr_en            | cfg_wr_data (capacity)
//   in      | in        | in_valid / in_stall  | in_cmd, in_data_in, in_count
//   out     | out       | out_valid / out_stall| out_data_out, out_byte_valid,
//           |           |                      | out_status, out_last
//
// A write request is accepted, then takes one write step. A read or line read
// is accepted, then runs a start step and a first pop for its first result,
// then pops one further byte per cycle while out_stall does not hold it; the
// single registered read port of the byte store sets that one-byte-a-cycle pace.
// Status-only results (full, empty, no line) come from the write or start step.
// Synchronous reset sets capacity to 63 and empties the ring; the store is not
// cleared. out_stall, while a result waits, holds the sequencer in its non-idle
// step; in_stall is low only in the idle step.
module byte_ring_fifo_with_line_read #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_data_in,
  input  logic [5:0] in_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_out,
  output logic       out_byte_valid,
  output logic [1:0] out_status,
  output logic       out_last
);
  import brfifo_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = (PW > 6) ? PW : 6;

  ucode_t    uc;
  seq_cond_t cond;

  logic [5:0]    cap_r, cap_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] nl_r, nl_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic          line_r, line_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [7:0] data_r;
  logic [5:0] count_r;
  logic [7:0] rdata_r;
  logic [7:0] out_data_r;
  logic       out_bv_r;
  stat_t      out_stat_r;
  logic       out_last_r;

  logic [7:0] mem [DEPTH];

  logic [CW-1:0] cap_x, cap_lim;
  logic [PW-1:0] cap_eff;
  logic [PW:0]   have_w;
  logic [PW-1:0] have;
  logic          full;
  logic [PW-1:0] rd_adv, wr_adv;
  logic [5:0]    cnt_eff;
  logic [CW-1:0] cnt_x, have_x;
  logic [PW-1:0] n_pop;
  logic          pop_nl, pop_last;
  logic          done, go, out_free, in_fire, emit;
  logic          we, re;
  logic [PW-1:0] rd_addr;
  logic [7:0]    e_data;
  logic          e_bv;
  stat_t         e_stat;
  logic          e_last;

  brfifo_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .uc    (uc)
  );

  // effective capacity, clamped between MIN_CAP and DEPTH - 1
  always_comb begin
    cap_x = CW'(cap_r);
    if (cap_x < CW'(MIN_CAP)) begin
      cap_lim = CW'(MIN_CAP);
    end else if (cap_x > CW'(DEPTH - 1)) begin
      cap_lim = CW'(DEPTH - 1);
    end else begin
      cap_lim = cap_x;
    end
    cap_eff = cap_lim[PW-1:0];
  end

  assign have_w = (wr_ptr_r >= rd_ptr_r) ? ({1'b0, wr_ptr_r} - {1'b0, rd_ptr_r})
                : ({1'b0, wr_ptr_r} + {1'b0, cap_eff} + (PW+1)'(1) - {1'b0, rd_ptr_r});
  assign have   = have_w[PW-1:0];
  assign full   = (have >= cap_eff);
  assign rd_adv = (rd_ptr_r == cap_eff) ? '0 : rd_ptr_r + 1'b1;
  assign wr_adv = (wr_ptr_r == cap_eff) ? '0 : wr_ptr_r + 1'b1;

  assign cnt_eff = (count_r == 6'd0) ? 6'd1 : count_r;
  assign cnt_x   = CW'(cnt_eff);
  assign have_x  = CW'(have);
  assign n_pop   = (cnt_x < have_x) ? cnt_x[PW-1:0] : have;

  assign pop_nl   = (rdata_r == NEWLINE);
  assign pop_last = line_r ? pop_nl : (rem_r == PW'(1));

  always_comb begin
    case (uc.op)
      OP_RD_START: done = (have == '0);
      OP_LN_START: done = (nl_r == '0);
      OP_POP:      done = pop_last;
      default:     done = 1'b1;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign go       = !uc.need_out || out_free;
  assign in_fire  = in_valid && uc.take_in;
  assign in_stall = !uc.take_in;

  assign cond.fire = in_fire;
  assign cond.cmd  = in_cmd;
  assign cond.go   = go;
  assign cond.done = done;

  assign emit = go && ((uc.op == OP_WRITE) || (uc.op == OP_POP) ||
                       (((uc.op == OP_RD_START) || (uc.op == OP_LN_START)) && done));

  // result payload per op
  always_comb begin
    e_data = 8'd0;
    e_bv   = 1'b0;
    e_stat = STAT_OK;
    e_last = 1'b1;
    case (uc.op)
      OP_WRITE:    e_stat = full ? STAT_FULL : STAT_OK;
      OP_RD_START: e_stat = STAT_EMPTY;
      OP_LN_START: e_stat = STAT_NOLINE;
      OP_POP: begin
        e_data = rdata_r;
        e_bv   = 1'b1;
        e_last = pop_last;
      end
      default: ;
    endcase
  end

  // store: one write port, one registered read port
  assign we = go && (uc.op == OP_WRITE) && !full;
  assign re = go && ((((uc.op == OP_RD_START) || (uc.op == OP_LN_START)) && !done) ||
                     ((uc.op == OP_POP) && !pop_last));
  // while popping, prefetch the byte after the one being sent
  assign rd_addr = (uc.op == OP_POP) ? rd_adv : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_ptr_r] <= data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    cap_nxt       = cap_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    nl_nxt        = nl_r;
    rem_nxt       = rem_r;
    line_nxt      = line_r;
    out_valid_nxt = out_valid_r;
    case (uc.op)
      OP_WRITE: begin
        if (we) begin
          wr_ptr_nxt = wr_adv;
          if (data_r == NEWLINE) begin
            nl_nxt = nl_r + 1'b1;
          end
        end
      end
      OP_RD_START: begin
        if (go && !done) begin
          rem_nxt  = n_pop;
          line_nxt = 1'b0;
        end
      end
      OP_LN_START: begin
        if (go && !done) begin
          line_nxt = 1'b1;
        end
      end
      OP_POP: begin
        if (go) begin
          rd_ptr_nxt = rd_adv;
          rem_nxt    = rem_r - 1'b1;
          if (pop_nl && (nl_r != '0)) begin
            nl_nxt = nl_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
    // a capacity write flushes the ring
    if (cfg_wr_en) begin
      cap_nxt    = cfg_wr_data;
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      nl_nxt     = '0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      nl_r        <= '0;
      rem_r       <= '0;
      line_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      nl_r        <= nl_nxt;
      rem_r       <= rem_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_r  <= in_data_in;
      count_r <= in_count;
    end
    if (emit) begin
      out_data_r <= e_data;
      out_bv_r   <= e_bv;
      out_stat_r <= e_stat;
      out_last_r <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_byte_valid = out_bv_r;
  assign out_status     = out_stat_r;
  assign out_last       = out_last_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r <= cap_eff) && (wr_ptr_r <= cap_eff))
    else $error("ring pointer beyond capacity");

  a_nl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nl_r <= have)
    else $error("newline count exceeds stored bytes");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result loaded over a waiting result");

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((uc.op == OP_POP) && !line_r) |-> (rem_r != '0))
    else $error("counted pop with nothing left");

endmodule
